@@ hw/rtl/u2u_pkg.sv @@
// Shared types and constants for the UTF-8 to 16-bit code unit decoder.
// Depends on nothing; every other RTL file imports it.
`default_nettype none

package u2u_pkg;

    // Byte classes as seen by the front end, before any sequence state
    typedef enum logic [1:0] {
        KIND_ASCII = 2'd0,  // 0xxxxxxx
        KIND_LEAD2 = 2'd1,  // 110xxxxx
        KIND_LEAD3 = 2'd2,  // 1110xxxx
        KIND_OTHER = 2'd3   // continuation or four-byte and longer lead
    } kind_t;

    // One classified item travelling from front to back
    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        logic       last_byte;
    } item_t;

    // Bit patterns for classification
    localparam logic [7:0] CONT_MASK  = 8'b1000_0000;
    localparam logic [7:0] LEAD2_MASK = 8'b1110_0000;
    localparam logic [7:0] LEAD2_TAG  = 8'b1100_0000;
    localparam logic [7:0] LEAD3_MASK = 8'b1111_0000;
    localparam logic [7:0] LEAD3_TAG  = 8'b1110_0000;
    localparam logic [7:0] LEAD2_BITS = 8'b0001_1111;
    localparam logic [7:0] LEAD3_BITS = 8'b0000_1111;
    localparam logic [7:0] PAY_BITS   = 8'b0011_1111;

    localparam int PEND_W = 2;
    localparam int PART_W = 10;
    localparam int CODE_W = 16;

    // Queue between front and back (depth must be a power of two)
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage

`default_nettype wire

@@ hw/rtl/utf8_to_utf16_decoder.sv @@
// UTF-8 to 16-bit code unit decoder (basic multilingual plane), top level.
// Depends on u2u_pkg, u2u_front, u2u_queue and u2u_back.
//
// Accepts one UTF-8 byte per cycle on data_valid/data_ready while the queue
// has room, with final_byte marking the last byte of a string, and returns
// one 16-bit code unit per complete sequence on code_valid/code_ready. The
// sustained rate is one byte per cycle while code_ready is held high, as the
// back end steps its sequence state on every popped byte. The completing
// byte waits in a two-entry queue between the classifying front end and the
// back end, which holds its result in an output register, so up to two more
// bytes are taken while a result waits. Continuations are not validated;
// stray continuation bytes and four-byte leads produce nothing, and a
// sequence cut short by the final byte is dropped.
`default_nettype none

module utf8_to_utf16_decoder
    import u2u_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              data_valid,
    output logic                   data_ready,
    input  wire logic [7:0]        data_byte,
    input  wire logic              final_byte,
    output logic                   code_valid,
    input  wire logic              code_ready,
    output logic [CODE_W-1:0]      code_unit
);

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_valid;
    item_t q_item;

    u2u_front u_front (
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .q_full     (q_full),
        .push       (push),
        .push_item  (push_item)
    );

    u2u_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    u2u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .pop        (pop),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_unit  (code_unit)
    );

endmodule

`default_nettype wire

@@ hw/rtl/u2u_front.sv @@
// Front end: input handshake and byte classification.
// Depends on u2u_pkg; feeds u2u_queue.
`default_nettype none

module u2u_front
    import u2u_pkg::*;
(
    input  wire logic       data_valid,
    output logic            data_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       final_byte,
    input  wire logic       q_full,
    output logic            push,
    output item_t           push_item
);

    kind_t kind;

    // Classify the byte by its leading bits
    always_comb
    begin
        if ((data_byte & CONT_MASK) == 8'h00)
        begin
            kind = KIND_ASCII;
        end
        else if ((data_byte & LEAD2_MASK) == LEAD2_TAG)
        begin
            kind = KIND_LEAD2;
        end
        else if ((data_byte & LEAD3_MASK) == LEAD3_TAG)
        begin
            kind = KIND_LEAD3;
        end
        else
        begin
            kind = KIND_OTHER;
        end
    end

    // Take an item whenever the queue has room
    assign data_ready          = !q_full;
    assign push                = data_valid && !q_full;
    assign push_item.kind      = kind;
    assign push_item.data      = data_byte;
    assign push_item.last_byte = final_byte;

endmodule

`default_nettype wire

@@ hw/rtl/u2u_queue.sv @@
// Small flop-based queue of classified items between front and back.
// Depends on u2u_pkg; read side is fall-through.
`default_nettype none

module u2u_queue
    import u2u_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t push_item,
    output logic       full,
    input  wire logic  pop,
    output logic       q_valid,
    output item_t      q_item
);

    item_t              entries_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full    = (count_reg == QCNT_W'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entries_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item; payload needs no reset
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/u2u_back.sv @@
// Back end: sequence state, code unit assembly and output register.
// Depends on u2u_pkg; drains u2u_queue.
`default_nettype none

module u2u_back
    import u2u_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         q_valid,
    input  wire item_t        q_item,
    output logic              pop,
    output logic              code_valid,
    input  wire logic         code_ready,
    output logic [CODE_W-1:0] code_unit
);

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic [PART_W-1:0] partial_reg;
    logic [PART_W-1:0] partial_next;
    logic              code_valid_reg;
    logic              code_valid_next;
    logic [CODE_W-1:0] code_unit_reg;
    logic [CODE_W-1:0] code_unit_next;
    logic              advance;
    logic              emit;
    logic [CODE_W-1:0] value;
    logic [CODE_W-1:0] joined;

    // Take the next item when the output register is free or being drained
    assign advance = !code_valid_reg || code_ready;
    assign pop     = q_valid && advance;
    assign joined  = {partial_reg, q_item.data[5:0] & PAY_BITS[5:0]};

    // Step the sequence state for the popped item
    always_comb
    begin
        emit         = 1'b0;
        value        = joined;
        pending_next = pending_reg;
        partial_next = partial_reg;
        if (pending_reg != '0)
        begin
            if (pending_reg == PEND_W'(1))
            begin
                emit         = 1'b1;
                pending_next = '0;
                partial_next = '0;
            end
            else
            begin
                pending_next = pending_reg - 1'b1;
                partial_next = joined[PART_W-1:0];
            end
        end
        else
        begin
            unique case (q_item.kind)
                KIND_ASCII:
                begin
                    emit  = 1'b1;
                    value = {8'h00, q_item.data};
                end
                KIND_LEAD2:
                begin
                    pending_next = PEND_W'(1);
                    partial_next = PART_W'(q_item.data & LEAD2_BITS);
                end
                KIND_LEAD3:
                begin
                    pending_next = PEND_W'(2);
                    partial_next = PART_W'(q_item.data & LEAD3_BITS);
                end
                default:
                begin
                    // stray continuation or long lead: drop
                end
            endcase
        end
        if (q_item.last_byte)
        begin
            pending_next = '0;
            partial_next = '0;
        end
    end

    // Load or hold the output register
    always_comb
    begin
        code_valid_next = advance ? (pop && emit) : 1'b1;
        code_unit_next  = (pop && emit) ? value : code_unit_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg    <= '0;
            partial_reg    <= '0;
            code_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                pending_reg <= pending_next;
                partial_reg <= partial_next;
            end
            code_valid_reg <= code_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_unit_reg <= code_unit_next;
    end

    assign code_valid = code_valid_reg;
    assign code_unit  = code_unit_reg;

    // A pending count of three is never produced
    a_no_pending3: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != PEND_W'(3))
        else $error("pending count reached three");

    // Nothing gathered while no sequence is open
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg == '0) |-> (partial_reg == '0))
        else $error("partial value held with no sequence open");

    // The final byte of a string closes any sequence
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && q_item.last_byte) |=> (pending_reg == '0))
        else $error("sequence left open after final byte");

endmodule

`default_nettype wire

@@ dv/tb_utf8_to_utf16_decoder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for utf8_to_utf16_decoder: a predictor of the byte
// decoder, a bursty byte driver, a stalling code unit receiver and a monitor.
// Depends on u2u_pkg and the decoder RTL.

module tb_utf8_to_utf16_decoder
    import u2u_pkg::*;
;

    localparam int ITEM_TARGET = 1800;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } stream_byte_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              data_valid = 1'b0;
    logic              data_ready;
    logic [7:0]        data_byte = 8'h00;
    logic              final_byte = 1'b0;
    logic              code_valid;
    logic              code_ready = 1'b0;
    logic [CODE_W-1:0] code_unit;

    // Bytes waiting to be driven and code units waiting to come out
    stream_byte_t      byte_stream[$];
    logic [CODE_W-1:0] expected_units[$];

    // Predictor state: continuation bytes still owed and payload so far
    logic [PEND_W-1:0] owed_bytes = '0;
    logic [PART_W-1:0] gathered_bits = '0;

    int unsigned bytes_sent = 0;
    int unsigned units_checked = 0;
    int unsigned strings_built = 0;
    int unsigned mismatches = 0;

    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    logic [7:0]  ready_pattern = 8'hFF;
    int unsigned pattern_left = 0;

    utf8_to_utf16_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_valid (data_valid),
        .data_ready (data_ready),
        .data_byte  (data_byte),
        .final_byte (final_byte),
        .code_valid (code_valid),
        .code_ready (code_ready),
        .code_unit  (code_unit)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic kind_t byte_kind(input logic [7:0] b);
        if ((b & CONT_MASK) == 8'h00)
            return KIND_ASCII;
        else if ((b & LEAD2_MASK) == LEAD2_TAG)
            return KIND_LEAD2;
        else if ((b & LEAD3_MASK) == LEAD3_TAG)
            return KIND_LEAD3;
        return KIND_OTHER;
    endfunction

    // Advance the decoder state by one byte and queue any finished code unit
    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [CODE_W-1:0] merged;
        kind_t             kind;
        begin
            merged = {gathered_bits, 6'b0} | CODE_W'(b & PAY_BITS);
            kind = byte_kind(b);
            if (owed_bytes != 0) begin
                if (owed_bytes == 1) begin
                    expected_units = {expected_units, merged};
                    owed_bytes = '0;
                    gathered_bits = '0;
                end
                else begin
                    owed_bytes = owed_bytes - 1'b1;
                    gathered_bits = merged[PART_W-1:0];
                end
            end
            else if (kind == KIND_ASCII) begin
                expected_units = {expected_units, CODE_W'(b)};
            end
            else if (kind == KIND_LEAD2) begin
                owed_bytes = PEND_W'(1);
                gathered_bits = PART_W'(b & LEAD2_BITS);
            end
            else if (kind == KIND_LEAD3) begin
                owed_bytes = PEND_W'(2);
                gathered_bits = PART_W'(b & LEAD3_BITS);
            end
            // a byte with final_byte set always ends the string
            if (last) begin
                owed_bytes = '0;
                gathered_bits = '0;
            end
        end
    endtask

    task automatic add_byte(input logic [7:0] b, input logic last);
        stream_byte_t item;
        begin
            item.value = b;
            item.last = last;
            byte_stream = {byte_stream, item};
            if (last)
                strings_built++;
        end
    endtask

    // Driver: record accepted items, then present the next one after any gap
    always @(posedge clk or negedge rst_n)
    begin
        stream_byte_t item;
        if (!rst_n) begin
            data_valid <= 1'b0;
            data_byte <= 8'h00;
            final_byte <= 1'b0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else begin
            if (data_valid && data_ready) begin
                decode_byte(data_byte, final_byte);
                bytes_sent++;
            end
            if (!data_valid || data_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    data_valid <= 1'b0;
                end
                else if (byte_stream.size() != 0) begin
                    item = byte_stream.pop_front();
                    data_valid <= 1'b1;
                    data_byte <= item.value;
                    final_byte <= item.last;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                    end
                    else begin
                        burst_left <= burst_left - 1;
                    end
                end
                else begin
                    data_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: rotate a stall pattern, reload it now and then
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            code_ready <= 1'b0;
            ready_pattern <= 8'hFF;
            pattern_left <= 0;
        end
        else begin
            code_ready <= ready_pattern[0];
            if (pattern_left == 0) begin
                ready_pattern <= ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
                pattern_left <= $urandom_range(16, 80);
            end
            else begin
                ready_pattern <= {ready_pattern[0], ready_pattern[7:1]};
                pattern_left <= pattern_left - 1;
            end
        end
    end

    // Monitor: compare each accepted code unit with the oldest expectation
    always @(posedge clk)
    begin
        logic [CODE_W-1:0] want;
        if (rst_n && code_valid && code_ready) begin
            if (expected_units.size() == 0) begin
                $error("code_unit: none expected, got %h", code_unit);
                mismatches++;
            end
            else begin
                want = expected_units.pop_front();
                if (code_unit !== want) begin
                    $error("code_unit: expected %h, got %h", want, code_unit);
                    mismatches++;
                end
                units_checked++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial
    begin
        int unsigned counted;
        int unsigned n_chars;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  seq[3];
        logic        last_char;

        // ASCII extremes, one without and one with the end flag
        add_byte(8'h00, 1'b0);
        add_byte(8'h7F, 1'b1);
        // two-byte extremes, overlong included
        add_byte(8'hC0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hDF, 1'b0);
        add_byte(8'hBF, 1'b0);
        // three-byte extremes and a surrogate value
        add_byte(8'hE0, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hEF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hBF, 1'b0);
        add_byte(8'hED, 1'b0);
        add_byte(8'hA0, 1'b0);
        add_byte(8'h80, 1'b1);
        // stray continuations and long leads are dropped
        add_byte(8'h80, 1'b0);
        add_byte(8'hF0, 1'b0);
        add_byte(8'hFF, 1'b0);
        // continuations taken blindly, whatever their value
        add_byte(8'hE2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'hFF, 1'b0);
        // sequences cut short: lead as final byte, then one continuation short
        add_byte(8'hC2, 1'b1);
        add_byte(8'hE2, 1'b0);
        add_byte(8'h82, 1'b1);
        add_byte(8'h41, 1'b1);

        // Random strings: mostly well-formed characters, some noise and cuts
        counted = 0;
        while (counted < ITEM_TARGET) begin
            n_chars = $urandom_range(1, 12);
            for (int c = 0; c < n_chars; c++) begin
                last_char = (c == n_chars - 1);
                pick = $urandom_range(0, 99);
                if (pick < 25) begin
                    seq[0] = 8'($urandom_range(0, 127));
                    len = 1;
                end
                else if (pick < 50) begin
                    seq[0] = 8'hC0 | 8'($urandom_range(0, 31));
                    len = 2;
                end
                else if (pick < 80) begin
                    seq[0] = 8'hE0 | 8'($urandom_range(0, 15));
                    len = 3;
                end
                else begin
                    seq[0] = 8'($urandom);
                    len = 1;
                end
                for (int k = 1; k < 3; k++)
                    seq[k] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                         : 8'h80 | 8'($urandom_range(0, 63));
                // cut a multibyte character short at the end of a string
                if (last_char && len > 1 && $urandom_range(0, 3) == 0)
                    len = $urandom_range(1, len - 1);
                for (int k = 0; k < len; k++) begin
                    add_byte(seq[k], last_char && (k == len - 1));
                    if (pick < 80 || byte_kind(seq[0]) != KIND_OTHER)
                        counted++;
                end
            end
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // hold until all items are accepted and every code unit is back
        while (byte_stream.size() != 0 || data_valid)
            @(posedge clk);
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Decoded %0d bytes in %0d strings, %0d code units checked.",
                 bytes_sent, strings_built, units_checked);
        $display("Covered ASCII, two- and three-byte sequences, skipped bytes and cut strings.");
        if (mismatches == 0 && expected_units.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Timed out with %0d code units outstanding.", expected_units.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
